// ===== design/ltc_pkg.sv =====
// ---------------------------------------------------------------------------
// ltc_pkg
// Shared constants, codes and controller/datapath types of the lagged
// transition counter.
// ---------------------------------------------------------------------------
package ltc_pkg;

   localparam int DEF_MAX_STATES  = 256;
   localparam int DEF_MAX_LAG     = 256;
   localparam int DEF_COUNT_WIDTH = 32;

   localparam int CFG_INDEX_WIDTH = 3;

   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_BINS   = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_Y_BINS   = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_ORIGIN = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_Y_ORIGIN = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_X_SCALE  = 3'd4;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_Y_SCALE  = 3'd5;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LAG      = 3'd6;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STRIDE   = 3'd7;

   localparam logic [8:0]  RST_BINS   = 9'd16;
   localparam logic [31:0] RST_SCALE  = 32'h0001_0000;
   localparam logic [8:0]  RST_LAG    = 9'd1;
   localparam logic [15:0] RST_STRIDE = 16'd1;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   typedef enum logic [1:0] {
      SEL_USER,
      SEL_FWD,
      SEL_REV
   } ltc_rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_CLEAR,
      WR_FWD,
      WR_REV
   } ltc_wr_sel_type;

   typedef struct packed {
      logic           load;
      logic           restart;
      logic           cap_start;
      logic           commit;
      ltc_rd_sel_type rd_sel;
      ltc_wr_sel_type wr_sel;
      logic           rsp_load;
   } ltc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic count_pair;
      logic self_pair;
   } ltc_status_type;

endpackage

// ===== design/ltc_ram.sv =====
// ---------------------------------------------------------------------------
// ltc_ram
// Generic RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ltc_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ltc_ctrl.sv =====
// ---------------------------------------------------------------------------
// ltc_ctrl
// Sequencer: clear pass, sample pipeline steps, count updates, reads and
// the result register handshake.
// ---------------------------------------------------------------------------
module ltc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_opcode,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ltc_pkg::ltc_cmd_type    cmd,
   input  ltc_pkg::ltc_status_type status
);
   import ltc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_BIN,
      ST_STATE,
      ST_PAIR,
      ST_RMW_FWD,
      ST_RMW_REV,
      ST_RD_ISSUE,
      ST_RD_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = SEL_USER;
      cmd.wr_sel   = WR_NONE;
      state_in     = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.load    = req_valid;
            cmd.restart = req_valid && (req_opcode == OP_RESTART);
            if (req_valid) begin
               case (req_opcode)
                  OP_SAMPLE: state_in = ST_DIFF;
                  OP_READ:   state_in = ST_RD_ISSUE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_BIN;
         ST_BIN:   state_in = ST_STATE;
         ST_STATE: begin
            cmd.cap_start = 1'b1;
            state_in      = ST_PAIR;
         end
         ST_PAIR: begin
            cmd.commit = 1'b1;
            cmd.rd_sel = SEL_FWD;
            state_in   = status.count_pair ? ST_RMW_FWD : ST_IDLE;
         end
         ST_RMW_FWD: begin
            cmd.wr_sel = WR_FWD;
            cmd.rd_sel = SEL_REV;
            state_in   = status.self_pair ? ST_IDLE : ST_RMW_REV;
         end
         ST_RMW_REV: begin
            cmd.wr_sel = WR_REV;
            state_in   = ST_IDLE;
         end
         ST_RD_ISSUE: state_in = ST_RD_DONE;
         ST_RD_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/ltc_dp.sv =====
// ---------------------------------------------------------------------------
// ltc_dp
// Datapath: configuration registers, binning pipeline, history RAM with
// its pointers, count RAM with saturating increment, result register.
// ---------------------------------------------------------------------------
module ltc_dp #(
   parameter int MAX_STATES  = ltc_pkg::DEF_MAX_STATES,
   parameter int MAX_LAG     = ltc_pkg::DEF_MAX_LAG,
   parameter int COUNT_WIDTH = ltc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ltc_pkg::CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                         csr_wdata,
   input  logic signed [31:0]                  req_x_sample,
   input  logic signed [31:0]                  req_y_sample,
   input  logic [7:0]                          req_row,
   input  logic [7:0]                          req_col,
   input  ltc_pkg::ltc_cmd_type                cmd,
   output ltc_pkg::ltc_status_type             status,
   output logic [31:0]                         rsp_count
);
   import ltc_pkg::*;

   localparam int SW    = $clog2(MAX_STATES);
   localparam int AW    = 2 * SW;
   localparam int DEPTH = MAX_STATES * (2 ** SW);
   localparam int HW    = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   localparam int LW    = $clog2(MAX_LAG + 1);
   localparam int CW    = COUNT_WIDTH;
   localparam int RW    = (CW > 32) ? CW : 32;

   // configuration
   logic [8:0]         x_bins_ff, y_bins_ff, lag_ff;
   logic signed [31:0] x_origin_ff, y_origin_ff;
   logic [31:0]        x_scale_ff, y_scale_ff;
   logic [15:0]        stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_bins_ff   <= RST_BINS;
         y_bins_ff   <= RST_BINS;
         x_origin_ff <= '0;
         y_origin_ff <= '0;
         x_scale_ff  <= RST_SCALE;
         y_scale_ff  <= RST_SCALE;
         lag_ff      <= RST_LAG;
         stride_ff   <= RST_STRIDE;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_X_BINS:   x_bins_ff   <= csr_wdata[8:0];
            CFG_Y_BINS:   y_bins_ff   <= csr_wdata[8:0];
            CFG_X_ORIGIN: x_origin_ff <= csr_wdata;
            CFG_Y_ORIGIN: y_origin_ff <= csr_wdata;
            CFG_X_SCALE:  x_scale_ff  <= csr_wdata;
            CFG_Y_SCALE:  y_scale_ff  <= csr_wdata;
            CFG_LAG:      lag_ff      <= csr_wdata[8:0];
            CFG_STRIDE:   stride_ff   <= csr_wdata[15:0];
            default:      ;
         endcase
      end
   end

   logic [8:0]    xb, yb;
   logic [LW-1:0] lg;
   logic [15:0]   st;

   always_comb begin
      xb = (x_bins_ff == 9'd0) ? 9'd1 : ((x_bins_ff > 9'd256) ? 9'd256 : x_bins_ff);
      yb = (y_bins_ff == 9'd0) ? 9'd1 : ((y_bins_ff > 9'd256) ? 9'd256 : y_bins_ff);
      if (lag_ff == 9'd0) begin
         lg = LW'(1);
      end else if (32'(lag_ff) > MAX_LAG) begin
         lg = LW'(MAX_LAG);
      end else begin
         lg = LW'(lag_ff);
      end
      st = (stride_ff == 16'd0) ? 16'd1 : stride_ff;
   end

   // input beat
   logic signed [31:0] x_ff, y_ff;
   logic [7:0]         row_ff, col_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_x_sample;
         y_ff   <= req_y_sample;
         row_ff <= req_row;
         col_ff <= req_col;
      end
   end

   // binning pipeline
   logic signed [32:0] diff_x, diff_y;
   logic [31:0]        mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;
   logic [63:0]        prod_x, prod_y;
   logic [31:0]        pbin_x_ff, pbin_y_ff;
   logic [7:0]         bin_x_ff, bin_y_ff, bin_x_in, bin_y_in;
   logic [17:0]        state_sum;
   logic [SW-1:0]      end_ff, end_in;

   always_comb begin
      diff_x   = 33'(x_ff) - 33'(x_origin_ff);
      diff_y   = 33'(y_ff) - 33'(y_origin_ff);
      mag_x_in = diff_x[32] ? 32'd0 : diff_x[31:0];
      mag_y_in = diff_y[32] ? 32'd0 : diff_y[31:0];
      prod_x   = 64'(mag_x_ff) * 64'(x_scale_ff);
      prod_y   = 64'(mag_y_ff) * 64'(y_scale_ff);
      bin_x_in = (pbin_x_ff >= 32'(xb)) ? 8'(xb - 9'd1) : pbin_x_ff[7:0];
      bin_y_in = (pbin_y_ff >= 32'(yb)) ? 8'(yb - 9'd1) : pbin_y_ff[7:0];
      state_sum = 18'(bin_x_ff) + 18'(xb) * 18'(bin_y_ff);
      end_in    = (32'(state_sum) >= MAX_STATES) ? SW'(MAX_STATES - 1) : SW'(state_sum);
   end

   always_ff @(posedge clock) begin
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      pbin_x_ff <= prod_x[63:32];
      pbin_y_ff <= prod_y[63:32];
      bin_x_ff  <= bin_x_in;
      bin_y_ff  <= bin_y_in;
      end_ff    <= end_in;
   end

   // history
   logic [HW-1:0] ptr_ff, ptr_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [15:0]   phase_ff, phase_in;
   logic [HW:0]   ptr_inc;
   logic [LW:0]   slot_sum;
   logic [HW-1:0] slot;
   logic [16:0]   phase_inc;
   logic [SW-1:0] hist_rd, start_ff;
   logic          filled;

   always_comb begin
      ptr_inc   = (HW + 1)'(ptr_ff) + (HW + 1)'(1);
      slot_sum  = (LW + 1)'(ptr_ff) + (LW + 1)'(MAX_LAG) - (LW + 1)'(lg);
      if (32'(slot_sum) >= MAX_LAG) begin
         slot_sum = slot_sum - (LW + 1)'(MAX_LAG);
      end
      slot      = HW'(slot_sum);
      phase_inc = 17'(phase_ff) + 17'd1;
      filled    = (fill_ff >= lg);

      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      if (cmd.restart) begin
         ptr_in   = '0;
         fill_in  = '0;
         phase_in = '0;
      end else if (cmd.commit) begin
         ptr_in = (32'(ptr_inc) >= MAX_LAG) ? '0 : HW'(ptr_inc);
         if (32'(fill_ff) < MAX_LAG) begin
            fill_in = fill_ff + LW'(1);
         end
         if (filled) begin
            phase_in = (phase_inc >= 17'(st)) ? 16'd0 : phase_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         fill_ff  <= '0;
         phase_ff <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_start) begin
         start_ff <= hist_rd;
      end
   end

   ltc_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_LAG)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (ptr_ff),
      .wr_data (end_ff),
      .rd_addr (slot),
      .rd_data (hist_rd)
   );

   // count table
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] cnt_rd_addr, cnt_wr_addr;
   logic [CW-1:0] cnt_rd, cnt_wr_data;
   logic [CW:0]   cnt_sum;
   logic          cnt_we, self_pair;

   assign self_pair = (start_ff == end_ff);

   always_comb begin
      case (cmd.rd_sel)
         SEL_FWD: cnt_rd_addr = {start_ff, end_ff};
         SEL_REV: cnt_rd_addr = {end_ff, start_ff};
         default: cnt_rd_addr = {SW'(row_ff), SW'(col_ff)};
      endcase
      case (cmd.wr_sel)
         WR_FWD:  cnt_wr_addr = {start_ff, end_ff};
         WR_REV:  cnt_wr_addr = {end_ff, start_ff};
         default: cnt_wr_addr = clr_ff;
      endcase
      cnt_we  = (cmd.wr_sel != WR_NONE);
      cnt_sum = (CW + 1)'(cnt_rd) +
                (((cmd.wr_sel == WR_FWD) && self_pair) ? (CW + 1)'(2) : (CW + 1)'(1));
      if (cmd.wr_sel == WR_CLEAR) begin
         cnt_wr_data = '0;
      end else begin
         cnt_wr_data = cnt_sum[CW] ? '1 : cnt_sum[CW-1:0];
      end
      clr_in = (cmd.wr_sel == WR_CLEAR) ? clr_ff + AW'(1) : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   ltc_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd)
   );

   // result
   logic [RW-1:0] cnt_ext;
   logic [31:0]   rsp_count_ff, rsp_count_in;
   logic          user_ok;

   always_comb begin
      user_ok = (32'(row_ff) < MAX_STATES) && (32'(col_ff) < MAX_STATES);
      cnt_ext = RW'(cnt_rd);
      if (!user_ok) begin
         rsp_count_in = 32'd0;
      end else if (cnt_ext > RW'(64'hFFFF_FFFF)) begin
         rsp_count_in = 32'hFFFF_FFFF;
      end else begin
         rsp_count_in = cnt_ext[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_count         = rsp_count_ff;
   assign status.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign status.count_pair = filled && (phase_ff == 16'd0);
   assign status.self_pair  = self_pair;

endmodule

// ===== design/lagged_transition_counter_2d.sv =====
// ---------------------------------------------------------------------------
// lagged_transition_counter_2d
// Each sample beat is binned per axis (floor((v - origin) * scale / 2**32),
// clamped) into state x_bin + x_bins * y_bin and paired with the state lag
// samples earlier; every stride-th pair adds one to count[start][end] and to
// count[end][start] (two for a self-transition), saturating. After reset a
// clearing pass writes zero to every count entry, with req_ready low. A
// sample then passes through the five-step binning sequence and, when it
// counts a pair, the read-modify-write of both entries (one entry for a
// self-transition) through the single count RAM; a new request is taken
// only when this is done. A read passes through the registered RAM read,
// then the result register, waiting while an earlier result is unaccepted;
// a restart returns straight to idle.
// ---------------------------------------------------------------------------
module lagged_transition_counter_2d #(
   parameter int MAX_STATES  = ltc_pkg::DEF_MAX_STATES,
   parameter int MAX_LAG     = ltc_pkg::DEF_MAX_LAG,
   parameter int COUNT_WIDTH = ltc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ltc_pkg::CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic signed [31:0]                  req_x_sample,
   input  logic signed [31:0]                  req_y_sample,
   input  logic [7:0]                          req_row,
   input  logic [7:0]                          req_col,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [31:0]                         rsp_count
);
   import ltc_pkg::*;

   ltc_cmd_type    cmd;
   ltc_status_type status;

   ltc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   ltc_dp #(
      .MAX_STATES  (MAX_STATES),
      .MAX_LAG     (MAX_LAG),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_x_sample (req_x_sample),
      .req_y_sample (req_y_sample),
      .req_row      (req_row),
      .req_col      (req_col),
      .cmd          (cmd),
      .status       (status),
      .rsp_count    (rsp_count)
   );

endmodule
